>>> rtl/wrcf_pkg.sv
// shared types and constants for the word result cache
// no dependencies
`timescale 1ns / 1ps

package wrcf_pkg;

    localparam int KEY_W      = 64;
    localparam int LEN_W      = 8;
    localparam int SLOT_W     = 4;
    localparam int CMD_W      = 2;
    localparam int IN_DATA_W  = 80;
    localparam int OUT_DATA_W = 8;

    typedef enum logic [CMD_W-1:0] {
        CMD_LOOKUP = 2'd0,
        CMD_PUT    = 2'd1,
        CMD_CLEAR  = 2'd2
    } t_cmd;

    // controller to datapath
    typedef struct packed {
        logic capture;
        logic step;
        logic finish;
        logic hit_ok;
    } t_ctrl_cmd;

    // datapath to controller
    typedef struct packed {
        logic is_lookup;
        logic walk_empty;
        logic match;
        logic last;
        logic out_free;
    } t_dp_status;

endpackage

>>> rtl/wrcf_ram.sv
// generic single write, single read ram with registered read data
// no dependencies
`timescale 1ns / 1ps

module wrcf_ram #(
    parameter int WIDTH = 73,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

>>> rtl/wrcf_ctrl.sv
// sequencer for the word result cache: accept, walk, finish
// depends on wrcf_pkg
`timescale 1ns / 1ps

module wrcf_ctrl (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_s_valid,
    output logic                   o_s_ready,
    input  wrcf_pkg::t_dp_status   i_status,
    output wrcf_pkg::t_ctrl_cmd    o_cmd
);
    import wrcf_pkg::*;

    typedef enum logic [2:0] {
        ST_IDLE  = 3'b001,
        ST_START = 3'b010,
        ST_CMP   = 3'b100
    } t_state;

    t_state    r_state;
    t_state    n_state;
    t_ctrl_cmd w_cmd;

    always_comb begin
        n_state = r_state;
        w_cmd   = '0;
        unique case (r_state)
            ST_IDLE: begin
                if (i_s_valid) begin
                    w_cmd.capture = 1'b1;
                    n_state       = ST_START;
                end
            end
            ST_START: begin
                if (i_status.is_lookup && !i_status.walk_empty) begin
                    n_state = ST_CMP;
                end else if (i_status.out_free) begin
                    w_cmd.finish = 1'b1;
                    n_state      = ST_IDLE;
                end
            end
            ST_CMP: begin
                w_cmd.hit_ok = 1'b1;
                if (i_status.match || i_status.last) begin
                    if (i_status.out_free) begin
                        w_cmd.finish = 1'b1;
                        n_state      = ST_IDLE;
                    end
                end else begin
                    w_cmd.step = 1'b1;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_s_ready = (r_state == ST_IDLE);
    assign o_cmd     = w_cmd;

    a_one_action: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(w_cmd.finish && w_cmd.step))
        else $error("finish and step together");

    a_capture_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.capture |=> (r_state == ST_START))
        else $error("capture did not start the item");

    a_finish_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.finish |-> i_status.out_free)
        else $error("result loaded into a full output register");

endmodule

>>> rtl/wrcf_dp.sv
// datapath for the word result cache: item register, fifo pointers,
// walk index, entry ram and output register; depends on wrcf_pkg, wrcf_ram
`timescale 1ns / 1ps

module wrcf_dp #(
    parameter int CACHE_ENTRIES = 16,
    parameter int MAX_WORD_LEN  = 32,
    parameter int KEY_BITS      = 64
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic [wrcf_pkg::CMD_W-1:0]           i_s_cmd,
    input  logic [wrcf_pkg::IN_DATA_W-1:0]       i_s_data,
    output logic                                 o_m_valid,
    input  logic                                 i_m_ready,
    output logic [wrcf_pkg::OUT_DATA_W-1:0]      o_m_data,
    input  wrcf_pkg::t_ctrl_cmd                  i_cmd,
    output wrcf_pkg::t_dp_status                 o_status
);
    import wrcf_pkg::*;

    localparam int IW    = $clog2(CACHE_ENTRIES);
    localparam int CW    = $clog2(CACHE_ENTRIES + 1);
    localparam int ENT_W = KEY_BITS + LEN_W + 1;

    localparam logic [IW-1:0]    LAST_IDX = IW'(CACHE_ENTRIES - 1);
    localparam logic [CW-1:0]    FULL_CNT = CW'(CACHE_ENTRIES);
    localparam logic [LEN_W-1:0] MAX_LEN  = LEN_W'(MAX_WORD_LEN);

    t_cmd                r_cmd;
    logic [KEY_BITS-1:0] r_key;
    logic [LEN_W-1:0]    r_len;
    logic                r_val;

    logic [IW-1:0] r_wp;
    logic [CW-1:0] r_cnt;
    logic [IW-1:0] r_idx;
    logic [CW-1:0] r_left;

    logic                  r_m_valid;
    logic [OUT_DATA_W-1:0] r_m_data;

    logic [IW-1:0]       w_newest;
    logic [IW-1:0]       w_prev;
    logic [IW-1:0]       w_raddr;
    logic [ENT_W-1:0]    w_rdata;
    logic [KEY_BITS-1:0] w_ent_key;
    logic [LEN_W-1:0]    w_ent_len;
    logic                w_ent_val;
    logic                w_match;
    logic                w_put_ok;
    logic                w_we;
    logic                w_out_free;
    logic                w_hit;
    logic                w_stored;
    logic [SLOT_W-1:0]   w_slot;

    assign w_newest = (r_wp == '0) ? LAST_IDX : r_wp - 1'b1;
    assign w_prev   = (r_idx == '0) ? LAST_IDX : r_idx - 1'b1;
    // on a step the next entry is addressed so its data is ready next cycle
    assign w_raddr  = i_cmd.step ? w_prev : r_idx;

    assign w_put_ok = (r_cmd == CMD_PUT) && (r_len != '0) && (r_len < MAX_LEN);
    assign w_we     = i_cmd.finish && w_put_ok;

    wrcf_ram #(
        .WIDTH (ENT_W),
        .DEPTH (CACHE_ENTRIES)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (r_wp),
        .i_wdata ({r_val, r_len, r_key}),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    assign w_ent_key = w_rdata[KEY_BITS-1:0];
    assign w_ent_len = w_rdata[KEY_BITS +: LEN_W];
    assign w_ent_val = w_rdata[ENT_W-1];
    assign w_match   = (w_ent_key == r_key) && (w_ent_len == r_len);

    assign w_out_free = !r_m_valid || i_m_ready;

    assign w_hit    = (r_cmd == CMD_LOOKUP) && i_cmd.hit_ok && w_match;
    assign w_stored = w_put_ok;
    assign w_slot   = w_hit ? SLOT_W'(r_idx) : (w_stored ? SLOT_W'(r_wp) : '0);

    // item register and walk position
    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_cmd  <= t_cmd'(i_s_cmd);
            r_key  <= i_s_data[KEY_BITS-1:0];
            r_len  <= i_s_data[KEY_W +: LEN_W];
            r_val  <= i_s_data[KEY_W + LEN_W];
            r_idx  <= w_newest;
            r_left <= r_cnt;
        end else if (i_cmd.step) begin
            r_idx  <= w_prev;
            r_left <= r_left - 1'b1;
        end
    end

    // fifo pointers: slots fill upward from zero, then the oldest is reused
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_cnt <= '0;
        end else if (i_cmd.finish) begin
            unique case (r_cmd)
                CMD_PUT: begin
                    if (w_put_ok) begin
                        r_wp <= (r_wp == LAST_IDX) ? '0 : r_wp + 1'b1;
                        if (r_cnt != FULL_CNT) begin
                            r_cnt <= r_cnt + 1'b1;
                        end
                    end
                end
                CMD_CLEAR: begin
                    r_wp  <= '0;
                    r_cnt <= '0;
                end
                default: begin
                end
            endcase
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m_valid <= 1'b0;
        end else if (i_cmd.finish) begin
            r_m_valid <= 1'b1;
        end else if (i_m_ready) begin
            r_m_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.finish) begin
            r_m_data <= {1'b0, w_stored, w_hit & w_ent_val, w_slot, w_hit};
        end
    end

    assign o_m_valid = r_m_valid;
    assign o_m_data  = r_m_data;

    assign o_status.is_lookup  = (r_cmd == CMD_LOOKUP);
    assign o_status.walk_empty = (r_left == '0);
    assign o_status.match      = w_match;
    assign o_status.last       = (r_left == CW'(1));
    assign o_status.out_free   = w_out_free;

    a_cnt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= FULL_CNT)
        else $error("entry count beyond depth");

    a_fill_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_cnt != FULL_CNT) |-> (r_wp == r_cnt[IW-1:0]))
        else $error("write pointer out of step with fill count");

    a_step_left: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.step |-> (r_left > CW'(1)))
        else $error("walk stepped past the oldest entry");

endmodule

>>> rtl/word_result_cache_fifo.sv
// top level of the word result cache with fifo replacement
// depends on wrcf_pkg, wrcf_ctrl, wrcf_dp, wrcf_ram
`timescale 1ns / 1ps

// usage
//   slave stream carries one command per beat: tuser is the command
//   (lookup, put, clear), tdata the word key, length and put value.
//   master stream returns exactly one result beat per command.
//   lookup walks the stored words from newest to oldest, one entry per
//   cycle through the entry ram read port, and stops at the first match.
//   after accept, put, clear and other codes finish from a start state;
//   a lookup with stored words goes on from there to a compare state.
//   one command is in work at a time; the next is taken once the
//   controller has returned to idle after its predecessor's result
//   is registered.
//   puts fill slots from zero upward, then overwrite the oldest entry.
//   reset empties the cache at once, with no clearing sweep.
//   the result sits in an output register: a stalled receiver does not
//   stop the next command being accepted, only its completion.
module word_result_cache_fifo #(
    parameter int CACHE_ENTRIES = 16,
    parameter int MAX_WORD_LEN  = 32,
    parameter int KEY_BITS      = 64
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_s_axis_tvalid,
    output logic                              o_s_axis_tready,
    // word_key[63:0], word_length[71:64], put_value[72], zero pad
    input  logic [wrcf_pkg::IN_DATA_W-1:0]    i_s_axis_tdata,
    // command[1:0]
    input  logic [wrcf_pkg::CMD_W-1:0]        i_s_axis_tuser,
    output logic                              o_m_axis_tvalid,
    input  logic                              i_m_axis_tready,
    // hit[0], slot[4:1], cached_value[5], stored[6], zero pad
    output logic [wrcf_pkg::OUT_DATA_W-1:0]   o_m_axis_tdata
);
    import wrcf_pkg::*;

    t_ctrl_cmd  w_cmd;
    t_dp_status w_status;

    wrcf_ctrl u_ctrl (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_s_valid (i_s_axis_tvalid),
        .o_s_ready (o_s_axis_tready),
        .i_status  (w_status),
        .o_cmd     (w_cmd)
    );

    wrcf_dp #(
        .CACHE_ENTRIES (CACHE_ENTRIES),
        .MAX_WORD_LEN  (MAX_WORD_LEN),
        .KEY_BITS      (KEY_BITS)
    ) u_dp (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_s_cmd   (i_s_axis_tuser),
        .i_s_data  (i_s_axis_tdata),
        .o_m_valid (o_m_axis_tvalid),
        .i_m_ready (i_m_axis_tready),
        .o_m_data  (o_m_axis_tdata),
        .i_cmd     (w_cmd),
        .o_status  (w_status)
    );

endmodule
